// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by cws_queue and cws_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/cws_pkg.sv =====
package cws_pkg;

   localparam int unsigned NUM_SECT = 5;
   localparam logic [8:0] LINE_END = 9'd256;

   typedef struct packed {
      logic [8:0] x_end;
      logic       w1;
      logic       w2;
   } section_type;

   typedef struct packed {
      section_type [NUM_SECT-1:0] sect;
      logic [NUM_SECT-1:0]        keep;
   } job_type;

   typedef struct packed {
      logic valid;
      logic pop;
   } qctl_type;

endpackage

// ===== hw/rtl/cws_front.sv =====
module cws_front (
   input  logic [7:0]       win1_left,
   input  logic [7:0]       win1_right,
   input  logic [7:0]       win2_left,
   input  logic [7:0]       win2_right,
   output cws_pkg::job_type job
);

   function automatic cws_pkg::section_type mk(input logic [8:0] x, input logic a,
                                               input logic b);
      cws_pkg::section_type s;
      s.x_end = x;
      s.w1    = a;
      s.w2    = b;
      return s;
   endfunction

   logic [8:0] l1, r1, l2, r2;
   logic       e1, e2;
   cws_pkg::section_type [cws_pkg::NUM_SECT-1:0] sect;

   assign l1 = {1'b0, win1_left};
   assign l2 = {1'b0, win2_left};
   assign r1 = {1'b0, win1_right} + 9'd1;
   assign r2 = {1'b0, win2_right} + 9'd1;
   assign e1 = win1_left <= win1_right;
   assign e2 = win2_left <= win2_right;

   always_comb begin
      sect[0] = mk(9'd0, 1'b0, 1'b0);
      sect[1] = mk(9'd0, 1'b0, 1'b0);
      sect[2] = mk(9'd0, 1'b0, 1'b0);
      sect[3] = mk(9'd0, 1'b0, 1'b0);
      sect[4] = mk(cws_pkg::LINE_END, 1'b0, 1'b0);
      if (e1 && e2) begin
         if (l1 < l2) begin
            if (r1 < l2) begin
               sect[0] = mk(l1, 1'b0, 1'b0);
               sect[1] = mk(r1, 1'b1, 1'b0);
               sect[2] = mk(l2, 1'b0, 1'b0);
               sect[3] = mk(r2, 1'b0, 1'b1);
            end else if (r1 < r2) begin
               sect[0] = mk(l1, 1'b0, 1'b0);
               sect[1] = mk(l2, 1'b1, 1'b0);
               sect[2] = mk(r1, 1'b1, 1'b1);
               sect[3] = mk(r2, 1'b0, 1'b1);
            end else begin
               sect[0] = mk(l1, 1'b0, 1'b0);
               sect[1] = mk(l2, 1'b1, 1'b0);
               sect[2] = mk(r2, 1'b1, 1'b1);
               sect[3] = mk(r1, 1'b1, 1'b0);
            end
         end else if (l1 < r2) begin
            if (r1 < r2) begin
               sect[0] = mk(l2, 1'b0, 1'b0);
               sect[1] = mk(l1, 1'b0, 1'b1);
               sect[2] = mk(r1, 1'b1, 1'b1);
               sect[3] = mk(r2, 1'b0, 1'b1);
            end else begin
               sect[0] = mk(l2, 1'b0, 1'b0);
               sect[1] = mk(l1, 1'b0, 1'b1);
               sect[2] = mk(r2, 1'b1, 1'b1);
               sect[3] = mk(r1, 1'b1, 1'b0);
            end
         end else begin
            sect[0] = mk(l2, 1'b0, 1'b0);
            sect[1] = mk(r2, 1'b0, 1'b1);
            sect[2] = mk(l1, 1'b0, 1'b0);
            sect[3] = mk(r1, 1'b1, 1'b0);
         end
      end else if (e1) begin
         sect[2] = mk(l1, 1'b0, 1'b0);
         sect[3] = mk(r1, 1'b1, 1'b0);
      end else if (e2) begin
         sect[2] = mk(l2, 1'b0, 1'b0);
         sect[3] = mk(r2, 1'b0, 1'b1);
      end
   end

   always_comb begin
      job.sect    = sect;
      job.keep[0] = sect[0].x_end != 9'd0;
      for (int i = 1; i < cws_pkg::NUM_SECT; i++) begin
         job.keep[i] = (sect[i].x_end != 9'd0) && (sect[i].x_end != sect[i-1].x_end);
      end
   end

endmodule

// ===== hw/rtl/cws_queue.sv =====
`include "assert_macros.svh"

module cws_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cws_pkg::job_type wr_job,
   output logic             full,
   output cws_pkg::job_type rd_job,
   output logic             rd_valid,
   input  logic             pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cws_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_FULL;
   assign rd_valid = count_ff != '0;
   assign rd_job   = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_FULL)
   `ASSERT_IMPLY(a_ptr_match, clock, reset, count_ff == '0 || count_ff == CNT_FULL,
                 wr_ptr_ff == rd_ptr_ff)

endmodule

// ===== hw/rtl/cws_back.sv =====
`include "assert_macros.svh"

module cws_back (
   input  logic              clock,
   input  logic              reset,
   input  cws_pkg::job_type  head,
   input  logic              head_valid,
   output cws_pkg::qctl_type qctl,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [8:0]        rsp_section_end,
   output logic              rsp_in_win1,
   output logic              rsp_in_win2,
   output logic              rsp_in_exactly_one,
   output logic              rsp_last
);

   logic [cws_pkg::NUM_SECT-1:0] sent_ff, sent_in, pending, pick, rest;
   logic                         load, pop;
   cws_pkg::section_type         sel;
   logic                         valid_ff, valid_in;
   logic [8:0]                   end_ff;
   logic                         w1_ff, w2_ff, last_ff;

   assign pending = head.keep & ~sent_ff;
   assign pick    = pending & (~pending + cws_pkg::NUM_SECT'(1));
   assign rest    = pending & ~pick;
   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign pop     = load && (rest == '0);

   assign qctl.valid = head_valid;
   assign qctl.pop   = pop;

   always_comb begin
      sel = '0;
      for (int i = 0; i < cws_pkg::NUM_SECT; i++) begin
         if (pick[i]) begin
            sel = sel | head.sect[i];
         end
      end
   end

   always_comb begin
      sent_in  = sent_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         sent_in  = pop ? '0 : (sent_ff | pick);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         end_ff  <= sel.x_end;
         w1_ff   <= sel.w1;
         w2_ff   <= sel.w2;
         last_ff <= sel.x_end == cws_pkg::LINE_END;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_section_end    = end_ff;
   assign rsp_in_win1        = w1_ff;
   assign rsp_in_win2        = w2_ff;
   assign rsp_in_exactly_one = w1_ff ^ w2_ff;
   assign rsp_last           = last_ff;

   `ASSERT_IMPLY(a_head_has_work, clock, reset, head_valid, pending != '0)
   `ASSERT_ALWAYS(a_sent_subset, clock, reset, !head_valid || ((sent_ff & ~head.keep) == '0))
   `ASSERT_IMPLY(a_pop_single, clock, reset, pop, $onehot(pending))
   `ASSERT_NEXT(a_pop_clears, clock, reset, pop, sent_ff == '0)

endmodule

// ===== hw/rtl/clip_window_sectioner_top.sv =====
// Clip window sectioner.
// Request channel: req_valid / req_stall with the inclusive left and right
// edges of two windows on a 256-pixel line. A window with left > right is
// empty. A request is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall, one section per response, in
// order of x: exclusive end, window one and two marks, exactly-one mark and
// last, which is set on the final section ending at 256.
// Each request gives one to five responses, one per cycle from a response
// register while rsp_stall is low; the number of responses is set by the
// number of distinct nonzero section ends.
// A taken request passes through the queue into the response register.
// Requests are classified on entry and wait in a QUEUE_DEPTH-entry queue,
// so new requests are taken while earlier ones are still being emitted;
// req_stall rises only when the queue is full.
// While rsp_stall is high the response register holds its section and the
// emitter waits; the queue keeps filling until full.
// Reset (synchronous, active high) empties the queue and drops any pending
// response.
module clip_window_sectioner_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_win1_left,
   input  logic [7:0] req_win1_right,
   input  logic [7:0] req_win2_left,
   input  logic [7:0] req_win2_right,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [8:0] rsp_section_end,
   output logic       rsp_in_win1,
   output logic       rsp_in_win2,
   output logic       rsp_in_exactly_one,
   output logic       rsp_last
);

   cws_pkg::job_type  new_job, head_job;
   cws_pkg::qctl_type qctl;
   logic              q_full, head_valid;

   cws_front u_front (
      .win1_left  (req_win1_left),
      .win1_right (req_win1_right),
      .win2_left  (req_win2_left),
      .win2_right (req_win2_right),
      .job        (new_job)
   );

   cws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid),
      .wr_job   (new_job),
      .full     (q_full),
      .rd_job   (head_job),
      .rd_valid (head_valid),
      .pop      (qctl.pop)
   );

   cws_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head_job),
      .head_valid         (head_valid),
      .qctl               (qctl),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_section_end    (rsp_section_end),
      .rsp_in_win1        (rsp_in_win1),
      .rsp_in_win2        (rsp_in_win2),
      .rsp_in_exactly_one (rsp_in_exactly_one),
      .rsp_last           (rsp_last)
   );

   assign req_stall = q_full;

endmodule
